// ----- design/btnf_pkg.sv -----
// ---------------------------------------------------------------------------
// btnf_pkg
// types, codes and tag helpers shared by the next-fit allocator modules
// ---------------------------------------------------------------------------
`default_nettype none
package btnf_pkg;
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NULL = 2'd1;
   localparam logic [1:0] STATUS_OOM  = 2'd2;

   localparam int unsigned FIRST_BLOCK_BYTES = 4096;
   localparam int unsigned MIN_BLOCK         = 16;
   localparam int unsigned PROLOGUE_PAYLOAD  = 8;
   localparam int unsigned FIRST_PAYLOAD     = 16;
   localparam int unsigned ADDR_W            = 21;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [31:0]       word_type;

   // one memory access issued by the sequencer
   typedef struct packed {
      logic     wr;
      addr_type addr;
      word_type wdata;
   } mem_req_type;

   function automatic addr_type tag_size(input word_type w);
      tag_size = {w[ADDR_W-1:3], 3'b000};
   endfunction
endpackage
`default_nettype wire

// ----- design/btnf_heap_ram.sv -----
// ---------------------------------------------------------------------------
// btnf_heap_ram
// word store of the heap with a clearing/init sweep after reset
// ---------------------------------------------------------------------------
`default_nettype none
module btnf_heap_ram #(
   parameter int unsigned WORDS = 16384
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire btnf_pkg::mem_req_type mreq,
   input  wire logic                  mreq_en,
   output logic [31:0]                rdata,
   output logic                       init_done
);
   import btnf_pkg::*;
   localparam int unsigned IW = $clog2(WORDS);
   localparam int unsigned HDR = FIRST_PAYLOAD / 4 - 1;
   localparam int unsigned FTR = (FIRST_PAYLOAD + FIRST_BLOCK_BYTES) / 4 - 2;
   localparam int unsigned EPI = FTR + 1;

   logic [31:0] mem [WORDS];
   logic [IW:0] clr_ff, clr_in;
   logic        in_range;
   logic [31:0] rd_ff;
   logic        oob_ff;
   word_type    init_word;

   assign in_range = (mreq.addr[ADDR_W-1:2] < ADDR_W'(WORDS));
   assign init_done = clr_ff[IW];
   assign clr_in = init_done ? clr_ff : clr_ff + 1'b1;

   always_comb begin
      init_word = '0;
      if (clr_ff[IW-1:0] == IW'(1) || clr_ff[IW-1:0] == IW'(2)) init_word = 32'd9;
      else if (clr_ff[IW-1:0] == IW'(HDR) || clr_ff[IW-1:0] == IW'(FTR))
         init_word = 32'(FIRST_BLOCK_BYTES);
      else if (clr_ff[IW-1:0] == IW'(EPI)) init_word = 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (!init_done) mem[clr_ff[IW-1:0]] <= init_word;
      else if (mreq_en && mreq.wr && in_range) mem[mreq.addr[IW+1:2]] <= mreq.wdata;
      rd_ff  <= mem[mreq.addr[IW+1:2]];
      oob_ff <= !in_range;
   end

   assign rdata = oob_ff ? '0 : rd_ff;
endmodule
`default_nettype wire

// ----- design/boundary_tag_next_fit_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// boundary_tag_next_fit_allocator_unit
// next-fit boundary tag heap allocator over a one-port word store
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// req       in         start & !busy      req_opcode, req_request_bytes, req_payload_offset
// rsp       out        rsp_valid strobe   rsp_granted_offset, rsp_status
//
// the header walk reads, waits for and checks the header of each block
// visited, then writes the tags. after reset a sweep over all HEAP_BYTES/4
// words initializes the store; busy is high meanwhile. results are a
// one-cycle strobe, the receiver cannot stall.
`default_nettype none
module boundary_tag_next_fit_allocator_unit #(
   parameter int unsigned HEAP_BYTES  = 65536,
   parameter int unsigned CHUNK_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_request_bytes,
   input  wire logic [15:0] req_payload_offset,
   output logic             rsp_valid,
   output logic [15:0]      rsp_granted_offset,
   output logic [1:0]       rsp_status
);
   import btnf_pkg::*;
   localparam int unsigned WORDS = HEAP_BYTES / 4;
   localparam int unsigned STEP_W = $clog2(WORDS) + 1;
   localparam addr_type CHUNK8 = addr_type'(((CHUNK_BYTES + 7) / 8) * 8);

   localparam logic [4:0] S_IDLE = 5'd0, S_SRD = 5'd1, S_SCHK = 5'd2,
      S_FRD = 5'd3, S_FCHK = 5'd4, S_FHDR = 5'd5, S_MPF = 5'd6, S_MNX = 5'd7,
      S_MCALC = 5'd8, S_MWH = 5'd9, S_MWF = 5'd10, S_PRD = 5'd11,
      S_PW1 = 5'd12, S_PW2 = 5'd13, S_PW3 = 5'd14, S_PW4 = 5'd15,
      S_GW1 = 5'd16, S_GW2 = 5'd17, S_GW3 = 5'd18, S_DONE = 5'd19,
      S_MPFW = 5'd20, S_MNXW = 5'd21, S_SRDW = 5'd22, S_FRDW = 5'd23,
      S_PRDW = 5'd24, S_PW5 = 5'd25;

   logic [4:0]  state_ff, state_in;
   logic        op_ff, op_in;
   addr_type    asize_ff, asize_in, off_ff, off_in;
   addr_type    bp_ff, bp_in, rover_ff, rover_in, end_ff, end_in;
   addr_type    size_ff, size_in, psize_ff, psize_in;
   logic        pfree_ff, pfree_in, pass2_ff, pass2_in, ext_ff, ext_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [15:0] gnt_ff, gnt_in;
   logic [1:0]  stat_ff, stat_in;
   logic        vld_ff, vld_in;
   mem_req_type mreq;
   logic        mreq_en;
   word_type    rdata;
   logic        init_done;
   addr_type    ext_amt, rsize, csum;
   logic        ralloc;

   btnf_heap_ram #(.WORDS(WORDS)) u_ram (
      .clock(clock), .reset(reset), .mreq(mreq), .mreq_en(mreq_en),
      .rdata(rdata), .init_done(init_done));

   assign rsize  = tag_size(rdata);
   assign ralloc = rdata[0];
   assign ext_amt = (asize_ff > CHUNK8) ? asize_ff : CHUNK8;
   assign csum = size_ff - asize_ff;

   assign busy = (state_ff != S_IDLE) || !init_done;
   assign rsp_valid = vld_ff;
   assign rsp_granted_offset = gnt_ff;
   assign rsp_status = stat_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; asize_in = asize_ff; off_in = off_ff;
      bp_in = bp_ff; rover_in = rover_ff; end_in = end_ff; size_in = size_ff;
      psize_in = psize_ff; pfree_in = pfree_ff; pass2_in = pass2_ff;
      ext_in = ext_ff; steps_in = steps_ff; gnt_in = gnt_ff; stat_in = stat_ff;
      vld_in = 1'b0;
      mreq = '{wr: 1'b0, addr: bp_ff - addr_type'(4), wdata: '0};
      mreq_en = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && init_done) begin
               op_in = req_opcode;
               off_in = addr_type'(req_payload_offset);
               asize_in = (req_request_bytes <= 16'd8) ? addr_type'(MIN_BLOCK) :
                  ((addr_type'(req_request_bytes) + addr_type'(15)) & ~addr_type'(7));
               gnt_in = '0; stat_in = STATUS_DONE; steps_in = '0;
               pass2_in = 1'b0; ext_in = 1'b0;
               if (req_opcode == OP_FREE) begin
                  bp_in = addr_type'(PROLOGUE_PAYLOAD); state_in = S_FRD;
               end else if (req_request_bytes == '0) begin
                  stat_in = STATUS_NULL; state_in = S_DONE;
               end else begin
                  bp_in = rover_ff; state_in = S_SRD;
               end
            end
         end
         S_SRD: begin
            if ((bp_ff >= end_ff) || (steps_ff == STEP_W'(WORDS)) ||
                (pass2_ff && bp_ff >= rover_ff)) begin
               if (!pass2_ff) begin
                  pass2_in = 1'b1; bp_in = addr_type'(PROLOGUE_PAYLOAD);
                  steps_in = '0;
               end else begin
                  state_in = S_GW1;
               end
            end else begin
               mreq_en = 1'b1; state_in = S_SRDW;
            end
         end
         S_SRDW: state_in = S_SCHK;
         S_SCHK: begin
            if (rsize == '0) begin
               if (!pass2_ff) begin
                  pass2_in = 1'b1; bp_in = addr_type'(PROLOGUE_PAYLOAD);
                  steps_in = '0; state_in = S_SRD;
               end else state_in = S_GW1;
            end else if (!ralloc && asize_ff <= rsize) begin
               size_in = rsize; state_in = S_PW1;
            end else begin
               bp_in = bp_ff + rsize; steps_in = steps_ff + 1'b1; state_in = S_SRD;
            end
         end
         S_FRD: begin
            if ((bp_ff >= end_ff) || (steps_ff == STEP_W'(WORDS))) state_in = S_DONE;
            else begin
               mreq_en = 1'b1; state_in = S_FRDW;
            end
         end
         S_FRDW: state_in = S_FCHK;
         S_FCHK: begin
            if (rsize == '0 || bp_ff > off_ff) state_in = S_DONE;
            else if (bp_ff == off_ff) begin
               if (bp_ff != addr_type'(PROLOGUE_PAYLOAD) && ralloc) begin
                  size_in = rsize; state_in = S_MPF;
               end else state_in = S_DONE;
            end else begin
               bp_in = bp_ff + rsize; steps_in = steps_ff + 1'b1; state_in = S_FRD;
            end
         end
         // merge: read prev footer, then next header
         S_MPF: begin
            mreq.addr = bp_ff - addr_type'(8); mreq_en = 1'b1; state_in = S_MPFW;
         end
         S_MPFW: begin
            mreq.addr = bp_ff - addr_type'(8); state_in = S_MNX;
         end
         S_MNX: begin
            pfree_in = !ralloc; psize_in = rsize;
            mreq.addr = bp_ff + size_ff - addr_type'(4); mreq_en = 1'b1;
            state_in = S_MNXW;
         end
         S_MNXW: begin
            mreq.addr = bp_ff + size_ff - addr_type'(4); state_in = S_MCALC;
         end
         S_MCALC: begin
            if (!ralloc) size_in = size_ff + rsize;
            state_in = S_FHDR;
         end
         S_FHDR: begin
            if (pfree_ff) begin
               size_in = size_ff + psize_ff; bp_in = bp_ff - psize_ff;
            end
            state_in = S_MWH;
         end
         S_MWH: begin
            mreq = '{wr: 1'b1, addr: bp_ff - addr_type'(4), wdata: word_type'(size_ff)};
            mreq_en = 1'b1; state_in = S_MWF;
         end
         S_MWF: begin
            mreq = '{wr: 1'b1, addr: bp_ff + size_ff - addr_type'(8),
                     wdata: word_type'(size_ff)};
            mreq_en = 1'b1; rover_in = bp_ff;
            state_in = (op_ff == OP_FREE) ? S_DONE : S_PRD;
         end
         S_PRD: begin
            mreq_en = 1'b1; state_in = S_PRDW;
         end
         S_PRDW: state_in = S_PW1;
         S_PW1: begin
            if (ext_ff) size_in = rsize;
            state_in = S_PW2;
         end
         S_PW2: begin
            gnt_in = bp_ff[15:0];
            if (csum >= addr_type'(MIN_BLOCK)) begin
               mreq = '{wr: 1'b1, addr: bp_ff - addr_type'(4),
                        wdata: word_type'(asize_ff) | 32'd1};
               mreq_en = 1'b1; state_in = S_PW3;
            end else begin
               mreq = '{wr: 1'b1, addr: bp_ff - addr_type'(4),
                        wdata: word_type'(size_ff) | 32'd1};
               mreq_en = 1'b1; asize_in = size_ff; state_in = S_PW4;
            end
         end
         S_PW3: begin
            mreq = '{wr: 1'b1, addr: bp_ff + asize_ff - addr_type'(8),
                     wdata: word_type'(asize_ff) | 32'd1};
            mreq_en = 1'b1; bp_in = bp_ff + asize_ff; size_in = csum;
            asize_in = csum; state_in = S_PW5;
            ext_in = 1'b0; pass2_in = 1'b0;
         end
         // split remainder header, its footer follows in S_GW2
         S_PW5: begin
            mreq = '{wr: 1'b1, addr: bp_ff - addr_type'(4), wdata: word_type'(size_ff)};
            mreq_en = 1'b1; state_in = S_GW2;
         end
         S_PW4: begin
            mreq = '{wr: 1'b1, addr: bp_ff + asize_ff - addr_type'(8),
                     wdata: word_type'(asize_ff) | 32'd1};
            mreq_en = 1'b1; state_in = S_DONE;
         end
         // grow: header, footer, epilogue; S_GW2 also writes the split remainder footer
         S_GW1: begin
            if (end_ff + ext_amt > addr_type'(HEAP_BYTES)) begin
               stat_in = STATUS_OOM; state_in = S_DONE;
            end else begin
               bp_in = end_ff; size_in = ext_amt; ext_in = 1'b1; pass2_in = 1'b1;
               end_in = end_ff + ext_amt;
               mreq = '{wr: 1'b1, addr: end_ff - addr_type'(4),
                        wdata: word_type'(ext_amt)};
               mreq_en = 1'b1; state_in = S_GW2;
            end
         end
         S_GW2: begin
            mreq = '{wr: 1'b1, addr: bp_ff + size_ff - addr_type'(8),
                     wdata: word_type'(size_ff)};
            mreq_en = 1'b1;
            state_in = ext_ff ? S_GW3 : S_DONE;
         end
         S_GW3: begin
            mreq = '{wr: 1'b1, addr: bp_ff + size_ff - addr_type'(4), wdata: 32'd1};
            mreq_en = 1'b1; state_in = S_MPF;
         end
         S_DONE: begin
            vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0;
         rover_ff <= addr_type'(PROLOGUE_PAYLOAD);
         end_ff <= addr_type'(FIRST_PAYLOAD + FIRST_BLOCK_BYTES);
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
         rover_ff <= rover_in; end_ff <= end_in;
      end
      op_ff <= op_in; asize_ff <= asize_in; off_ff <= off_in; bp_ff <= bp_in;
      size_ff <= size_in; psize_ff <= psize_in; pfree_ff <= pfree_in;
      pass2_ff <= pass2_in; ext_ff <= ext_in; steps_ff <= steps_in;
      gnt_ff <= gnt_in; stat_ff <= stat_in;
   end

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result while idle");
   a_end_grows: assert property (@(posedge clock) disable iff (reset)
      end_ff >= $past(end_ff) || $past(reset)) else $error("heap end shrank");
   a_end_bound: assert property (@(posedge clock) disable iff (reset)
      end_ff <= addr_type'(HEAP_BYTES)) else $error("heap end past store");
endmodule
`default_nettype wire
